// ===== hw/rtl/mlr_pkg.sv =====
// mlr_pkg: shared types and constants of the midpoint line rasterizer
// no dependencies; used by mlr_front, mlr_queue, mlr_back and the top level

package mlr_pkg;

   // coordinate width of every point field
   localparam int COORD_BITS = 6;

   // decision value and its increments, signed, with headroom for 2 * (big - small)
   localparam int D_BITS = COORD_BITS + 3;

   // packed stream widths, rounded up to whole bytes
   localparam int REQ_DATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

   // line queue between front and back
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef logic [COORD_BITS-1:0]    coord_type;
   typedef logic signed [D_BITS-1:0] decision_type;

   // one classified line, ready to step
   typedef struct packed {
      coord_type    x_start;
      coord_type    y_start;
      logic         x_major;     // |dx| > |dy|
      logic         neg_x;       // x moves toward smaller columns
      logic         neg_y;       // y moves toward smaller rows
      coord_type    steps;       // major axis length, pixels minus one
      decision_type d_init;      // big - 2 * small
      decision_type inc_keep;    // -2 * small
      decision_type inc_move;    // 2 * (big - small)
   } line_setup_type;

endpackage

// ===== hw/rtl/mlr_front.sv =====
// mlr_front: accepts line transactions and classifies them into step setups
// depends on mlr_pkg

module mlr_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [mlr_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   output logic                                  setup_valid,
   input  logic                                  setup_ready,
   output mlr_pkg::line_setup_type               setup_data
);

   mlr_pkg::coord_type      xs, ys, xe, ye;
   logic signed [mlr_pkg::COORD_BITS:0] dx, dy;
   mlr_pkg::coord_type      adx, ady, big, small_len;
   mlr_pkg::decision_type   big_ext, small_ext;
   mlr_pkg::line_setup_type setup_in;
   mlr_pkg::line_setup_type setup_ff;
   logic                    valid_ff, valid_in;
   logic                    accept;

   // unpack the request fields
   assign xs = req_tdata[0*mlr_pkg::COORD_BITS +: mlr_pkg::COORD_BITS];
   assign ys = req_tdata[1*mlr_pkg::COORD_BITS +: mlr_pkg::COORD_BITS];
   assign xe = req_tdata[2*mlr_pkg::COORD_BITS +: mlr_pkg::COORD_BITS];
   assign ye = req_tdata[3*mlr_pkg::COORD_BITS +: mlr_pkg::COORD_BITS];

   // deltas, magnitudes and major axis choice
   always_comb begin
      dx = $signed({1'b0, xe}) - $signed({1'b0, xs});
      dy = $signed({1'b0, ye}) - $signed({1'b0, ys});
      adx = dx[mlr_pkg::COORD_BITS] ? mlr_pkg::COORD_BITS'(-dx)
                                    : dx[mlr_pkg::COORD_BITS-1:0];
      ady = dy[mlr_pkg::COORD_BITS] ? mlr_pkg::COORD_BITS'(-dy)
                                    : dy[mlr_pkg::COORD_BITS-1:0];
      setup_in.x_major = adx > ady;
      big       = setup_in.x_major ? adx : ady;
      small_len = setup_in.x_major ? ady : adx;
      big_ext   = $signed({{(mlr_pkg::D_BITS-mlr_pkg::COORD_BITS){1'b0}}, big});
      small_ext = $signed({{(mlr_pkg::D_BITS-mlr_pkg::COORD_BITS){1'b0}}, small_len});
      setup_in.x_start  = xs;
      setup_in.y_start  = ys;
      setup_in.neg_x    = dx[mlr_pkg::COORD_BITS];
      setup_in.neg_y    = dy[mlr_pkg::COORD_BITS];
      setup_in.steps    = big;
      setup_in.d_init   = big_ext - (small_ext + small_ext);
      setup_in.inc_keep = -(small_ext + small_ext);
      setup_in.inc_move = (big_ext - small_ext) + (big_ext - small_ext);
   end

   // one holding stage; refills while the queue takes the current line
   assign req_tready = !valid_ff || setup_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (setup_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         setup_ff <= setup_in;
      end
   end

   assign setup_valid = valid_ff;
   assign setup_data  = setup_ff;

endmodule

// ===== hw/rtl/mlr_queue.sv =====
// mlr_queue: short first-in first-out queue of classified lines
// depends on mlr_pkg

module mlr_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,     // valid from the writer
   output logic                    push_ready,
   input  mlr_pkg::line_setup_type push_data,
   output logic                    pop_valid,
   input  logic                    pop_ready,      // ready from the reader
   output mlr_pkg::line_setup_type pop_data
);

   mlr_pkg::line_setup_type                  entry_ff [mlr_pkg::QUEUE_DEPTH];
   logic [mlr_pkg::QUEUE_PTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [mlr_pkg::QUEUE_PTR_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [mlr_pkg::QUEUE_CNT_BITS-1:0]       count_ff, count_in;
   logic                                     push, pop;

   assign push_ready = count_ff != mlr_pkg::QUEUE_CNT_BITS'(mlr_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_ready && pop_valid;
   assign pop_data   = entry_ff[rd_ptr_ff];

   // pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == mlr_pkg::QUEUE_PTR_BITS'(mlr_pkg::QUEUE_DEPTH - 1))
                   ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == mlr_pkg::QUEUE_PTR_BITS'(mlr_pkg::QUEUE_DEPTH - 1))
                   ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/mlr_back.sv =====
// mlr_back: steps one line at a time and drives the pixel output register
// depends on mlr_pkg

module mlr_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    line_valid,
   output logic                    line_ready,
   input  mlr_pkg::line_setup_type line_data,
   output logic                    pix_valid,
   input  logic                    pix_ready,
   output mlr_pkg::coord_type      pix_x,
   output mlr_pkg::coord_type      pix_y,
   output logic                    pix_last
);

   logic                    active_ff, active_in;
   mlr_pkg::coord_type      x_ff, x_in, y_ff, y_in, count_ff, count_in;
   mlr_pkg::decision_type   d_ff, d_in;
   mlr_pkg::line_setup_type line_ff;
   logic                    out_valid_ff, out_valid_in;
   mlr_pkg::coord_type      out_x_ff, out_y_ff;
   logic                    out_last_ff;
   logic                    slot_free, emit, at_last, load, move;
   logic                    step_x, step_y;

   // output slot handshake
   assign slot_free  = !out_valid_ff || pix_ready;
   assign emit       = active_ff && slot_free;
   assign at_last    = count_ff == '0;
   assign load       = line_valid && (!active_ff || (emit && at_last));
   assign line_ready = !active_ff || (emit && at_last);

   // midpoint decision and axis moves
   assign move   = d_ff[mlr_pkg::D_BITS-1] || (d_ff == '0);
   assign step_x = line_ff.x_major || move;
   assign step_y = !line_ff.x_major || move;

   always_comb begin
      active_in = active_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      d_in      = d_ff;
      count_in  = count_ff;
      if (load) begin
         active_in = 1'b1;
         x_in      = line_data.x_start;
         y_in      = line_data.y_start;
         d_in      = line_data.d_init;
         count_in  = line_data.steps;
      end else if (emit && at_last) begin
         active_in = 1'b0;
      end else if (emit) begin
         count_in = count_ff - 1'b1;
         d_in     = d_ff + (move ? line_ff.inc_move : line_ff.inc_keep);
         if (step_x) begin
            x_in = line_ff.neg_x ? x_ff - 1'b1 : x_ff + 1'b1;
         end
         if (step_y) begin
            y_in = line_ff.neg_y ? y_ff - 1'b1 : y_ff + 1'b1;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (pix_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // stepper datapath
   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      d_ff     <= d_in;
      count_ff <= count_in;
      if (load) begin
         line_ff <= line_data;
      end
   end

   // pixel output register
   always_ff @(posedge clock) begin
      if (emit) begin
         out_x_ff    <= x_ff;
         out_y_ff    <= y_ff;
         out_last_ff <= at_last;
      end
   end

   assign pix_valid = out_valid_ff;
   assign pix_x     = out_x_ff;
   assign pix_y     = out_y_ff;
   assign pix_last  = out_last_ff;

endmodule

// ===== hw/rtl/midpoint_line_rasterizer.sv =====
// midpoint_line_rasterizer: top level, front classifier, line queue and pixel stepper
// depends on mlr_pkg, mlr_front, mlr_queue, mlr_back
//
//   channel | direction | payload
//   req_    | in        | tdata: x_start, y_start, x_end, y_end (lowest bits first)
//   rsp_    | out       | tdata: pixel_x, pixel_y; tlast: last_pixel
//
// a line of major length M gives M + 1 pixels, one per cycle from the stepper while
// rsp_tready allows, so up to 64 pixels per line; the stepper loads the next line on
// the cycle of the previous last pixel when one waits in the queue, else when it comes
// the front adds one register stage and the queue holds two lines
// synchronous reset clears all handshake state; no state is kept between lines
// rsp_tready low holds the stepper; req_tready drops once front and queue are full

module midpoint_line_rasterizer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mlr_pkg::REQ_DATA_BITS-1:0] req_tdata,  // x_start, y_start, x_end, y_end
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mlr_pkg::RSP_DATA_BITS-1:0] rsp_tdata,  // pixel_x, pixel_y, zero fill
   output logic                              rsp_tlast   // last_pixel
);

   logic                    setup_valid, setup_ready;
   mlr_pkg::line_setup_type setup_data;
   logic                    line_valid, line_ready;
   mlr_pkg::line_setup_type line_data;
   mlr_pkg::coord_type      pix_x, pix_y;

   // front: accept and classify
   mlr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .setup_valid (setup_valid),
      .setup_ready (setup_ready),
      .setup_data  (setup_data)
   );

   // queue between front and back
   mlr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (setup_valid),
      .push_ready (setup_ready),
      .push_data  (setup_data),
      .pop_valid  (line_valid),
      .pop_ready  (line_ready),
      .pop_data   (line_data)
   );

   // back: step the line and emit pixels
   mlr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .line_valid (line_valid),
      .line_ready (line_ready),
      .line_data  (line_data),
      .pix_valid  (rsp_tvalid),
      .pix_ready  (rsp_tready),
      .pix_x      (pix_x),
      .pix_y      (pix_y),
      .pix_last   (rsp_tlast)
   );

   // pack the pixel transaction
   assign rsp_tdata = mlr_pkg::RSP_DATA_BITS'({pix_y, pix_x});

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench of the midpoint line rasterizer
// depends on mlr_pkg and midpoint_line_rasterizer
// lines go in, every pixel is predicted and checked

module tb_top;

   // req tdata layout, first member in the highest bits
   typedef struct packed {
      mlr_pkg::coord_type y_end;
      mlr_pkg::coord_type x_end;
      mlr_pkg::coord_type y_start;
      mlr_pkg::coord_type x_start;
   } line_item_type;

   typedef struct packed {
      mlr_pkg::coord_type pixel_x;
      mlr_pkg::coord_type pixel_y;
      logic               last_pixel;
   } pixel_item_type;

   typedef enum {SHAPE_ANY, SHAPE_SHORT, SHAPE_AXIS, SHAPE_DIAG} shape_kind_type;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 80;
   localparam int LONG_HOLD      = 500;
   localparam int HOLD_AT_LINE   = 200;
   localparam int MAX_REPORTS    = 10;

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [mlr_pkg::REQ_DATA_BITS-1:0] req_tdata  = '0;  // x_start, y_start, x_end, y_end
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [mlr_pkg::RSP_DATA_BITS-1:0] rsp_tdata;        // pixel_x, pixel_y, zero fill
   logic                              rsp_tlast;        // last_pixel

   line_item_type  pending_lines[$];
   pixel_item_type expected_pixels[$];

   int   send_idle_pct   = 0;
   int   recv_idle_pct   = 0;
   int   line_count      = 0;
   int   mismatch_count  = 0;
   int   quiet_cycles    = 0;
   int   hold_left       = 0;
   bit   long_hold_done  = 1'b0;
   logic req_taken       = 1'b0;

   midpoint_line_rasterizer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // clock, period 12
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // midpoint stepping of one line, pixels appended in drawing order
   function automatic void rasterize_line(input line_item_type line);
      int   dx, dy, adx, ady, major_len, minor_len;
      int   step_major, step_minor, d, x, y;
      logic x_major, move;
      pixel_item_type px;
      dx = int'(line.x_end) - int'(line.x_start);
      dy = int'(line.y_end) - int'(line.y_start);
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      // equal deltas count as y-major
      x_major = adx > ady;
      major_len = x_major ? adx : ady;
      minor_len = x_major ? ady : adx;
      step_major = x_major ? ((dx < 0) ? -1 : 1) : ((dy < 0) ? -1 : 1);
      step_minor = x_major ? ((dy < 0) ? -1 : 1) : ((dx < 0) ? -1 : 1);
      d = major_len - 2 * minor_len;
      x = int'(line.x_start);
      y = int'(line.y_start);
      for (int k = 0; k <= major_len; k++) begin
         if (k > 0) begin
            move = d <= 0;
            d += move ? 2 * (major_len - minor_len) : -2 * minor_len;
            if (x_major) begin
               x += step_major;
               if (move) y += step_minor;
            end else begin
               y += step_major;
               if (move) x += step_minor;
            end
         end
         px.pixel_x    = x[mlr_pkg::COORD_BITS-1:0];
         px.pixel_y    = y[mlr_pkg::COORD_BITS-1:0];
         px.last_pixel = (k == major_len);
         expected_pixels = {expected_pixels, px};
      end
   endfunction

   // driver: offers pending lines, one per transaction
   always @(negedge clock) begin
      logic next_valid;
      next_valid = req_tvalid;
      if (!reset) begin
         if (req_tvalid && req_taken) next_valid = 1'b0;
         if (!next_valid && pending_lines.size() > 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            next_valid = 1'b1;
            req_tdata <= pending_lines.pop_front();
         end
      end
      req_tvalid <= next_valid;
   end

   // receiver: random back-pressure plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!long_hold_done && line_count >= HOLD_AT_LINE) begin
         hold_left      = LONG_HOLD;
         long_hold_done = 1'b1;
         rsp_tready     <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor: checks pixels, predicts accepted lines, watchdog
   always @(posedge clock) begin
      pixel_item_type got, want;
      logic req_fire, rsp_fire;
      req_fire = !reset && req_tvalid && req_tready;
      rsp_fire = !reset && rsp_tvalid && rsp_tready;
      req_taken <= req_fire;
      if (rsp_fire) begin
         got.pixel_x    = rsp_tdata[mlr_pkg::COORD_BITS-1:0];
         got.pixel_y    = rsp_tdata[2*mlr_pkg::COORD_BITS-1:mlr_pkg::COORD_BITS];
         got.last_pixel = rsp_tlast;
         if (expected_pixels.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("unexpected pixel x=%0d y=%0d last=%0b",
                        got.pixel_x, got.pixel_y, got.last_pixel);
            mismatch_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
                got.last_pixel !== want.last_pixel) begin
               if (mismatch_count < MAX_REPORTS)
                  $display({"pixel mismatch: expected x=%0d y=%0d last=%0b, ",
                            "got x=%0d y=%0d last=%0b"},
                           want.pixel_x, want.pixel_y, want.last_pixel,
                           got.pixel_x, got.pixel_y, got.last_pixel);
               mismatch_count++;
            end
         end
      end
      if (req_fire) begin
         rasterize_line(line_item_type'(req_tdata));
         line_count++;
      end
      if (req_fire || rsp_fire || reset) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   function automatic line_item_type make_line(input int xs, input int ys,
                                               input int xe, input int ye);
      line_item_type line;
      line.x_start = xs[mlr_pkg::COORD_BITS-1:0];
      line.y_start = ys[mlr_pkg::COORD_BITS-1:0];
      line.x_end   = xe[mlr_pkg::COORD_BITS-1:0];
      line.y_end   = ye[mlr_pkg::COORD_BITS-1:0];
      return line;
   endfunction

   // append one line to the pending queue
   function automatic void queue_line(input int xs, input int ys, input int xe, input int ye);
      pending_lines = {pending_lines, make_line(xs, ys, xe, ye)};
   endfunction

   // one idling profile: queue random lines and wait until all are taken
   task automatic run_phase(input int count, input int send_pct, input int recv_pct);
      shape_kind_type shape;
      int             pick, xs, ys, xe, ye, span;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(9);
         shape = (pick < 6) ? SHAPE_ANY : (pick < 8) ? SHAPE_SHORT :
                 (pick < 9) ? SHAPE_AXIS : SHAPE_DIAG;
         xs = $urandom_range(63);
         ys = $urandom_range(63);
         xe = $urandom_range(63);
         ye = $urandom_range(63);
         case (shape)
            SHAPE_SHORT: begin
               xe = xs + int'($urandom_range(6)) - 3;
               ye = ys + int'($urandom_range(6)) - 3;
               xe = (xe < 0) ? 0 : (xe > 63) ? 63 : xe;
               ye = (ye < 0) ? 0 : (ye > 63) ? 63 : ye;
            end
            SHAPE_AXIS: begin
               if ($urandom_range(1)) ye = ys;
               else xe = xs;
            end
            SHAPE_DIAG: begin
               span = (xe > xs) ? xe - xs : xs - xe;
               ys = $urandom_range(63 - span);
               ye = ys + span;
               if ($urandom_range(1)) begin
                  pick = ys;
                  ys   = ye;
                  ye   = pick;
               end
            end
            default: ;
         endcase
         queue_line(xs, ys, xe, ye);
      end
      do @(posedge clock); while (pending_lines.size() != 0 || req_tvalid);
   endtask

   // stimulus sequence and final verdict
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // degenerate lines, full-length axes, diagonals, every octant, tie boundaries
      queue_line( 0,  0,  0,  0);
      queue_line(63, 63, 63, 63);
      queue_line( 0,  5, 63,  5);
      queue_line(63, 40,  0, 40);
      queue_line( 7,  0,  7, 63);
      queue_line(50, 63, 50,  0);
      queue_line( 0,  0, 63, 63);
      queue_line(63,  0,  0, 63);
      queue_line( 0, 63, 63,  0);
      queue_line(10, 10, 40, 20);
      queue_line(40, 20, 10, 10);
      queue_line(10, 20, 40, 10);
      queue_line(40, 10, 10, 20);
      queue_line(10, 10, 20, 40);
      queue_line(20, 40, 10, 10);
      queue_line(20, 10, 10, 40);
      queue_line(10, 40, 20, 10);
      queue_line( 0,  0,  5,  4);
      queue_line( 0,  0,  4,  5);
      queue_line( 5,  5,  6,  5);
      queue_line( 5,  5,  5,  6);
      queue_line(62, 62, 63, 63);

      run_phase(78, 18, 70);
      run_phase(85, 70, 18);
      run_phase(85, 0, 0);

      // drain, then allow the pipeline to settle
      do @(posedge clock); while (expected_pixels.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_pixels.size() != 0) mismatch_count++;

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
